>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HVT_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HVT_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> hw/rtl/hvt_pkg.sv
`default_nettype none

package hvt_pkg;

    localparam int NUM_ROWS      = 4;
    localparam int NUM_LANES     = 3;
    localparam int NUM_CFG_REGS  = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int COEF_W        = 32;
    localparam int PROD_W        = 2 * COEF_W;
    // Four products of up to 2^62 in magnitude sum to up to 2^64, which needs all 66 bits.
    localparam int SUM_W         = PROD_W + 2;

    typedef logic signed [COEF_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;

    localparam t_word SAT_MAX = 32'sh7FFF_FFFF;
    localparam t_word SAT_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COL0_ROWS01 = 3'd0,
        REG_COL0_ROWS23 = 3'd1,
        REG_COL1_ROWS01 = 3'd2,
        REG_COL1_ROWS23 = 3'd3,
        REG_COL2_ROWS01 = 3'd4,
        REG_COL2_ROWS23 = 3'd5
    } t_cfg_idx;

    // Load strobes that the top level hands to each lane.
    typedef struct packed {
        logic load_mul;
        logic load_sum;
    } t_lane_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/hvt_if.sv
`default_nettype none

interface hvt_in_if import hvt_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word in_x;
    t_word in_y;
    t_word in_z;
    t_word in_w;

    modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                    input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                    output ready);
endinterface

interface hvt_out_if import hvt_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word out_x;
    t_word out_y;
    t_word out_z;
    logic  saturated;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input saturated, output ready);
endinterface

interface hvt_cfg_if import hvt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_cfg_data            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hvt_lane.sv
`default_nettype none

// One output column: four products in the first stage, their sum in the second.
module hvt_lane import hvt_pkg::*; (
    input  wire       i_clk,
    input  t_lane_ctl i_ctl,
    input  t_word     i_vec  [NUM_ROWS],
    input  t_word     i_coef [NUM_ROWS],
    output t_sum      o_sum
);

    t_prod r_prod [NUM_ROWS];
    t_sum  r_sum;
    t_sum  n_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_mul) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_prod[r] <= t_prod'(i_vec[r]) * t_prod'(i_coef[r]);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_sum = n_sum + SUM_W'(r_prod[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

>>> hw/rtl/hvt_merge.sv
`default_nettype none

// Scales each lane sum down, clips it to 32 bits and folds the clip flags together.
module hvt_merge import hvt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire   i_clk,
    input  logic  i_load,
    input  t_sum  i_sum [NUM_LANES],
    output t_word o_comp [NUM_LANES],
    output logic  o_sat
);

    t_word r_comp [NUM_LANES];
    logic  r_sat;
    t_word n_comp [NUM_LANES];
    logic  n_sat;

    always_comb begin
        t_sum                    shifted;
        logic [SUM_W-COEF_W:0]   upper;
        n_sat = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            // Arithmetic shift rounds toward minus infinity.
            shifted = i_sum[l] >>> FRAC_BITS;
            upper   = shifted[SUM_W-1:COEF_W-1];
            if ((&upper) || !(|upper)) begin
                n_comp[l] = shifted[COEF_W-1:0];
            end else begin
                n_comp[l] = shifted[SUM_W-1] ? SAT_MIN : SAT_MAX;
                n_sat     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_comp <= n_comp;
            r_sat  <= n_sat;
        end
    end

    assign o_comp = r_comp;
    assign o_sat  = r_sat;

endmodule

`default_nettype wire

>>> hw/rtl/homogeneous_vector_transform_core.sv
`default_nettype none

// Homogeneous 4x4 matrix-vector transform in signed Q16.16. Each input transfer
// carries a vector (x, y, z, w); each output transfer carries the first three
// components of that row vector times the configured row-major matrix, with
// out[c] the sum over r of in[r] * m[r][c], scaled down by FRAC_BITS with an
// arithmetic shift (rounding toward minus infinity) and clipped to 32 bits.
// The saturated flag is set when any component was clipped. The twelve used
// coefficients live in six 64-bit registers, two coefficients per register,
// the even row in bits 31:0 and the odd row in bits 63:32; writes to indexes
// past the last register are dropped. Write the registers only while no
// vector is in flight. The block takes one vector per clock while the pipeline
// is not stalled, and passes it through one stage of twelve 32x32 multipliers, one stage
// that adds the four products of each column, and an output register that
// holds the scaled and clipped result. Each stage stalls on its own, so an
// empty stage keeps taking vectors while the output waits to be taken.
module homogeneous_vector_transform_core import hvt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    hvt_in_if.sink           i_in,
    hvt_out_if.source        o_out,
    hvt_cfg_if.sink          i_cfg
);

    // Configuration registers, indexed as the register map lists them.
    t_cfg_data r_cfg [NUM_CFG_REGS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                REG_COL0_ROWS01: r_cfg[REG_COL0_ROWS01] <= i_cfg.data;
                REG_COL0_ROWS23: r_cfg[REG_COL0_ROWS23] <= i_cfg.data;
                REG_COL1_ROWS01: r_cfg[REG_COL1_ROWS01] <= i_cfg.data;
                REG_COL1_ROWS23: r_cfg[REG_COL1_ROWS23] <= i_cfg.data;
                REG_COL2_ROWS01: r_cfg[REG_COL2_ROWS01] <= i_cfg.data;
                REG_COL2_ROWS23: r_cfg[REG_COL2_ROWS23] <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline occupancy. A stage may load when it is empty or when the stage
    // after it loads in the same cycle.
    logic r_v1;
    logic r_v2;
    logic r_vo;
    logic n_v1;
    logic n_v2;
    logic n_vo;
    logic rdy1;
    logic rdy2;
    logic rdy_o;

    assign rdy_o = !r_vo || o_out.ready;
    assign rdy2  = !r_v2 || rdy_o;
    assign rdy1  = !r_v1 || rdy2;

    assign i_in.ready = rdy1;

    assign n_v1 = rdy1  ? i_in.valid : r_v1;
    assign n_v2 = rdy2  ? r_v1       : r_v2;
    assign n_vo = rdy_o ? r_v2       : r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_vo <= n_vo;
        end
    end

    t_lane_ctl lane_ctl;

    assign lane_ctl.load_mul = rdy1 && i_in.valid;
    assign lane_ctl.load_sum = rdy2 && r_v1;

    // The vector is shared by all lanes; each lane sees the column it owns.
    t_word vec [NUM_ROWS];
    t_word coef [NUM_LANES][NUM_ROWS];
    t_sum  lane_sum [NUM_LANES];

    assign vec[0] = i_in.in_x;
    assign vec[1] = i_in.in_y;
    assign vec[2] = i_in.in_z;
    assign vec[3] = i_in.in_w;

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
            assign coef[c][r] = r_cfg[2 * c + r / 2][COEF_W * (r % 2) +: COEF_W];
        end

        hvt_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_vec  (vec),
            .i_coef (coef[c]),
            .o_sum  (lane_sum[c])
        );
    end

    // The merge stage doubles as the output register.
    t_word comp [NUM_LANES];
    logic  sat;

    hvt_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_load (rdy_o && r_v2),
        .i_sum  (lane_sum),
        .o_comp (comp),
        .o_sat  (sat)
    );

    assign o_out.valid     = r_vo;
    assign o_out.out_x     = comp[0];
    assign o_out.out_y     = comp[1];
    assign o_out.out_z     = comp[2];
    assign o_out.saturated = sat;

`include "assert_macros.svh"

    // An accepted vector always lands in the multiply stage.
    `HVT_ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, i_in.valid && i_in.ready, r_v1,
        "vector lost at input")

    // A sum that cannot move on keeps its stage and its value.
    `HVT_ASSERT_NEXT(a_sum_holds, i_clk, i_rst_n, r_v2 && !rdy_o,
        r_v2 && $stable(lane_sum[0]) && $stable(lane_sum[1]) && $stable(lane_sum[2]),
        "sum stage overwritten while stalled")

    // A set clip flag means some component sits at a rail.
    `HVT_ASSERT_NOW(a_sat_rail, i_clk, i_rst_n, o_out.valid && o_out.saturated,
        o_out.out_x == SAT_MAX || o_out.out_x == SAT_MIN ||
        o_out.out_y == SAT_MAX || o_out.out_y == SAT_MIN ||
        o_out.out_z == SAT_MAX || o_out.out_z == SAT_MIN,
        "clip flag without clipped component")

endmodule

`default_nettype wire

>>> sim/hvt_transform_checker.sv
`default_nettype none

// Watches the vector, result and register channels of the transform core. It keeps its own
// copy of the twelve coefficients, predicts each result when a vector is taken, and compares
// each result transfer against the oldest prediction.
module hvt_transform_checker import hvt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    hvt_in_if    i_in,
    hvt_out_if   i_out,
    hvt_cfg_if   i_cfg,
    output int   o_error_count,
    output int   o_pending
);

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        logic  sat;
    } t_xform_result;

    t_cfg_data     coef_regs [NUM_CFG_REGS];
    t_xform_result predicted_results [$];

    // Even rows sit in the low word of a register, odd rows in the high word.
    function automatic t_word coef_of(int row, int col);
        t_cfg_data word;
        word = coef_regs[2 * col + row / 2];
        return (row % 2 == 1) ? t_word'(word[63:32]) : t_word'(word[31:0]);
    endfunction

    function automatic t_xform_result transform_vector(t_word vec [NUM_ROWS]);
        t_xform_result res;
        t_word         lane [NUM_LANES];
        t_sum          acc;
        t_sum          scaled;
        res = '0;
        for (int c = 0; c < NUM_LANES; c++) begin
            acc = '0;
            for (int r = 0; r < NUM_ROWS; r++) begin
                acc = acc + t_sum'(t_prod'(vec[r]) * t_prod'(coef_of(r, c)));
            end
            // Arithmetic shift, so negative sums round toward minus infinity.
            scaled = acc >>> FRAC_BITS;
            if (scaled > t_sum'(SAT_MAX)) begin
                lane[c] = SAT_MAX;
                res.sat = 1'b1;
            end else if (scaled < t_sum'(SAT_MIN)) begin
                lane[c] = SAT_MIN;
                res.sat = 1'b1;
            end else begin
                lane[c] = t_word'(scaled);
            end
        end
        res.x = lane[0];
        res.y = lane[1];
        res.z = lane[2];
        return res;
    endfunction

    task automatic check_field(string field, logic [COEF_W-1:0] want, logic [COEF_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            o_error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_word         vec [NUM_ROWS];
        t_xform_result want;
        if (!i_rst_n) begin
            foreach (coef_regs[i]) begin
                coef_regs[i] = '0;
            end
            predicted_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready && i_cfg.index < NUM_CFG_REGS) begin
                coef_regs[i_cfg.index] = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                vec = '{i_in.in_x, i_in.in_y, i_in.in_z, i_in.in_w};
                predicted_results.push_back(transform_vector(vec));
            end
            if (i_out.valid && i_out.ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result transfer with no vector outstanding");
                    o_error_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("out_x", want.x, i_out.out_x);
                    check_field("out_y", want.y, i_out.out_y);
                    check_field("out_z", want.z, i_out.out_z);
                    check_field("saturated", COEF_W'(want.sat), COEF_W'(i_out.saturated));
                end
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

`default_nettype wire

>>> sim/homogeneous_vector_transform_core_tb.sv
`default_nettype none

// Top of the transform core testbench. It makes the clock and reset, programs the matrix
// between phases, drives vectors and throttles the result channel. All prediction and
// comparison lives in the checker instance; this module only gives the verdict.
module homogeneous_vector_transform_core_tb;
    import hvt_pkg::*;

    localparam int       FRAC_BITS       = 16;
    localparam int       HALF_PERIOD     = 2;
    localparam int       RESET_CYCLES    = 6;
    // Multiplier stage, adder stage and output register.
    localparam int       PIPE_LATENCY    = 3;
    localparam int       RANDOM_PHASES   = 7;
    localparam int       ITEMS_PER_PHASE = 250;
    localparam int       IDLE_PERCENT    = 18;
    localparam int       HOLD_OFF_CYCLES = 300;
    localparam int       HOLD_PHASE      = 1;
    localparam int       HOLD_AFTER      = 60;
    localparam int       DRAIN_PHASE     = 2;
    localparam int       STEADY_PHASE    = 3;
    localparam longint   RUN_LIMIT       = 2_000_000;
    // Q16.16 spans for typical transforms: coefficients within +-8.0, vectors within +-1024.0.
    localparam int       COEF_SPAN       = 32'h0008_0000;
    localparam int       VEC_SPAN        = 32'h0400_0000;
    localparam t_word    ONE_Q16         = 32'sh0001_0000;
    // Indexes the block has no register behind; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = CFG_IDX_W'(NUM_CFG_REGS);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = {CFG_IDX_W{1'b1}};

    typedef enum int {
        STYLE_RAW,
        STYLE_SMALL,
        STYLE_EXTREME
    } t_value_style;

    logic  i_clk;
    logic  i_rst_n;
    int    error_count;
    int    pending_results;

    // Flow control knobs. The receiver process owns the hold-off countdown; the main
    // process only loads it.
    int    sink_hold_cycles = 0;
    bit    sink_steady      = 1'b0;
    bit    src_steady       = 1'b0;

    // Working matrix, m[row][column]; only the first three columns exist in the block.
    t_word mtx [NUM_ROWS][NUM_LANES];

    hvt_in_if  in_ch ();
    hvt_out_if out_ch ();
    hvt_cfg_if cfg_ch ();

    homogeneous_vector_transform_core #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hvt_transform_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg         (cfg_ch),
        .o_error_count (error_count),
        .o_pending     (pending_results)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Hard stop in case a handshake never completes.
    initial begin
        #(RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Result receiver. Outside the hold-off and the steady phase, ready drops at random
    // about eighteen percent of the time.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                sink_hold_cycles--;
            end else if (sink_steady) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    function automatic t_word pick_value(t_value_style style, int span);
        case (style)
            STYLE_RAW: begin
                return t_word'($urandom());
            end
            STYLE_SMALL: begin
                return t_word'(int'($urandom_range(2 * span)) - span);
            end
            default: begin
                case ($urandom_range(5))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return '0;
                    3:       return t_word'(1);
                    4:       return t_word'(-1);
                    default: return ONE_Q16;
                endcase
            end
        endcase
    endfunction

    // Each task below is entered just after a falling edge and returns just after one, so
    // every input changes half a period away from the sampling edge.
    task automatic send_vector(input t_word vx, input t_word vy, input t_word vz,
                               input t_word vw);
        while (!src_steady && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_x  <= vx;
        in_ch.in_y  <= vy;
        in_ch.in_z  <= vz;
        in_ch.in_w  <= vw;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Stops offering vectors and waits until every predicted result has been taken, then
    // lets the pipeline settle before the registers may change.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input t_cfg_data value);
        while ($urandom_range(99) < IDLE_PERCENT) begin
            cfg_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // Writes all six registers from mtx, starting at a random register, with one write to
    // an unmapped index slipped in at a random place.
    task automatic load_matrix();
        t_cfg_data words [NUM_CFG_REGS];
        int        first;
        int        spare_at;
        for (int c = 0; c < NUM_LANES; c++) begin
            for (int h = 0; h < 2; h++) begin
                words[2 * c + h] = {mtx[2 * h + 1][c], mtx[2 * h][c]};
            end
        end
        first    = $urandom_range(NUM_CFG_REGS - 1);
        spare_at = $urandom_range(NUM_CFG_REGS);
        for (int k = 0; k <= NUM_CFG_REGS; k++) begin
            if (k == spare_at) begin
                write_cfg($urandom_range(1) ? CFG_IDX_UNUSED_LO : CFG_IDX_UNUSED_HI,
                          {$urandom(), $urandom()});
            end
            if (k < NUM_CFG_REGS) begin
                write_cfg(t_cfg_idx'((first + k) % NUM_CFG_REGS),
                          words[(first + k) % NUM_CFG_REGS]);
            end
        end
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic fill_matrix(input t_word value);
        foreach (mtx[r, c]) begin
            mtx[r][c] = value;
        end
    endtask

    task automatic random_matrix(input t_value_style style);
        foreach (mtx[r, c]) begin
            mtx[r][c] = ($urandom_range(9) == 0) ? pick_value(STYLE_EXTREME, 0)
                                                 : pick_value(style, COEF_SPAN);
        end
    endtask

    // Mostly well-scaled vectors, many with w = 1.0 as a point would carry, plus raw bit
    // patterns that push the sums into saturation and vectors built from extreme values.
    task automatic send_random_vector();
        t_value_style style;
        t_word        w;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: style = STYLE_SMALL;
            6, 7:             style = STYLE_RAW;
            default:          style = STYLE_EXTREME;
        endcase
        w = (style == STYLE_SMALL && $urandom_range(1) == 1) ? ONE_Q16
                                                             : pick_value(style, VEC_SPAN);
        send_vector(pick_value(style, VEC_SPAN), pick_value(style, VEC_SPAN),
                    pick_value(style, VEC_SPAN), w);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.in_x   = '0;
        in_ch.in_y   = '0;
        in_ch.in_z   = '0;
        in_ch.in_w   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With the registers still at their reset value every component must come out zero.
        send_vector(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        send_vector(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);

        // Identity with a translation in row 3: x gains 2.5, y loses 3.0. Points near the
        // top and bottom of the range clip in one lane and not the other.
        wait_drained();
        fill_matrix('0);
        mtx[0][0] = ONE_Q16;
        mtx[1][1] = ONE_Q16;
        mtx[2][2] = ONE_Q16;
        mtx[3][0] = 32'sh0002_8000;
        mtx[3][1] = -32'sh0003_0000;
        load_matrix();
        send_vector(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, ONE_Q16);
        send_vector(SAT_MAX, SAT_MAX, SAT_MAX, ONE_Q16);
        send_vector(SAT_MIN, SAT_MIN, SAT_MIN, ONE_Q16);
        send_vector('0, '0, '0, '0);
        send_vector(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);

        // Coefficients of one least significant bit expose the rounding of the final shift:
        // a sum just below zero must give -1, not 0.
        wait_drained();
        fill_matrix(t_word'(1));
        load_matrix();
        send_vector(t_word'(-1), '0, '0, '0);
        send_vector(t_word'(1), '0, '0, '0);
        send_vector(-32'sh0001_0000, '0, '0, '0);
        send_vector(-32'sh0001_0001, '0, '0, '0);

        // Most negative coefficients: the four largest products, both clipping directions,
        // and a mix that cancels.
        wait_drained();
        fill_matrix(SAT_MIN);
        load_matrix();
        send_vector(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
        send_vector(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        send_vector(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);

        // Most positive coefficients.
        wait_drained();
        fill_matrix(SAT_MAX);
        load_matrix();
        send_vector(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        send_vector(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);

        // Random phases, each with a fresh matrix. One phase stalls the receiver for a long
        // stretch while vectors keep coming, one pauses the sender until the pipeline is
        // empty, and one runs both sides without any idle cycles.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            random_matrix(t_value_style'(p % 3));
            load_matrix();
            src_steady  = (p == STEADY_PHASE);
            sink_steady = (p == STEADY_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == HOLD_PHASE && n == HOLD_AFTER) begin
                    sink_hold_cycles = HOLD_OFF_CYCLES;
                end
                if (p == DRAIN_PHASE && n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                send_random_vector();
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_results != 0) begin
            @(negedge i_clk);
        end
        // Keep watching after the drain so that a stray extra result would still be caught.
        repeat (4 * PIPE_LATENCY) @(negedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
